FILE: rtl/core/clgt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clgt_pkg
// shared types, codes and constants of the chs/lba geometry translator
// ----------------------------------------------------------------------------
package clgt_pkg;

	localparam int LBA_W  = 28;
	localparam int CYL_W  = 16;
	localparam int HEAD_W = 5;
	localparam int HIN_W  = 4;
	localparam int SEC_W  = 8;
	localparam int OP_W   = 2;
	localparam int IDX_W  = 2;

	// divider: one quotient bit per step
	localparam int DSR_W     = 8;
	localparam int DIV_CNT_W = $clog2(LBA_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LBA_W - 1);

	// default geometry search
	localparam int SPT_W  = 6;
	localparam logic [SPT_W-1:0]  SPT_START  = 6'd63;
	localparam logic [HEAD_W-1:0] HEAD_START = 5'd16;
	localparam logic [LBA_W-1:0]  CYL_MAX    = 28'd65535;

	// operation codes
	localparam logic [OP_W-1:0] OP_CHS2LBA = 2'd0;
	localparam logic [OP_W-1:0] OP_LBA2CHS = 2'd1;
	localparam logic [OP_W-1:0] OP_GEOM    = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TOTAL_SECTORS = 2'd0;
	localparam logic [IDX_W-1:0] REG_CYL_COUNT     = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEAD_COUNT    = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPT           = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_SEC,
		ST_DIV_HEAD,
		ST_SRCH_SPT,
		ST_SRCH_HEAD,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic [LBA_W-1:0]  total_sectors;
		logic [CYL_W-1:0]  cylinder_count;
		logic [HEAD_W-1:0] head_count;
		logic [SEC_W-1:0]  sectors_per_track;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [LBA_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [LBA_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/clgt_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clgt_cfg
// geometry and capacity register file with plain write port
// ----------------------------------------------------------------------------
module clgt_cfg import clgt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [LBA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOTAL_SECTORS: cfg_q.total_sectors     <= cfg_wdata;
				REG_CYL_COUNT:     cfg_q.cylinder_count    <= cfg_wdata[CYL_W-1:0];
				REG_HEAD_COUNT:    cfg_q.head_count        <= cfg_wdata[HEAD_W-1:0];
				REG_SPT:           cfg_q.sectors_per_track <= cfg_wdata[SEC_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/clgt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clgt_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module clgt_div import clgt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LBA_W-1:0]     dvd_q;
	logic [DSR_W-1:0]     rem_q;
	logic [DSR_W-1:0]     dsr_q;

	logic [DSR_W:0] trial;
	logic [DSR_W:0] diff;
	logic           ge;

	assign trial = {rem_q, dvd_q[LBA_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			dvd_q <= {dvd_q[LBA_W-2:0], ge};
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

FILE: rtl/core/chs_lba_geometry_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chs_lba_geometry_translator
// disk address translator between cylinder/head/sector and linear addresses
// ----------------------------------------------------------------------------
// One word at a time: the input is stalled from the cycle after a word is
// taken until its result has been moved into the output register. Every
// division goes through one shared bit-serial divider with a 28-bit
// quotient. Op 0 (chs to lba) uses a 16x5 multiply at accept and a 21x8
// multiply-add in the next cycle. Op 1 (lba to chs) is two chained
// divisions. Op 2 (default geometry) tries one divisor per division, 63
// down to 2 for sectors per track and 16 down to 2 for heads. Range
// errors of ops 0 and 1 and the unused op 3 go straight to the finish
// step. A finished result waits in the output register while the next word
// is taken.
// ----------------------------------------------------------------------------
module chs_lba_geometry_translator import clgt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [LBA_W-1:0]  cfg_wdata,
	// input words
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [OP_W-1:0]   op,
	input  wire logic [CYL_W-1:0]  cylinder_in,
	input  wire logic [HIN_W-1:0]  head_in,
	input  wire logic [SEC_W-1:0]  sector_in,
	input  wire logic [LBA_W-1:0]  lba_in,
	// result words
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   ok,
	output logic [LBA_W-1:0]       lba_out,
	output logic [CYL_W-1:0]       cylinder_out,
	output logic [HEAD_W-1:0]      head_out,
	output logic [SEC_W-1:0]       sector_out
);

	localparam int PROD_W = CYL_W + HEAD_W;
	localparam int MUL_W  = PROD_W + SEC_W + 1;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	st_t state_q, state_d;

	// working registers
	logic [PROD_W-1:0] prod_q;     // cylinder * heads + head
	logic [SEC_W-1:0]  sin_q;
	logic [SPT_W-1:0]  spt_q;      // sectors per track candidate
	logic [HEAD_W-1:0] hd_q;       // head count candidate
	logic [LBA_W-1:0]  rest_q;     // capacity / chosen sectors per track

	// pending result
	logic              res_ok_q;
	logic [LBA_W-1:0]  res_lba_q;
	logic [CYL_W-1:0]  res_cyl_q;
	logic [HEAD_W-1:0] res_head_q;
	logic [SEC_W-1:0]  res_sec_q;

	// output register
	logic              out_valid_q;
	logic              ok_q;
	logic [LBA_W-1:0]  lba_q;
	logic [CYL_W-1:0]  cyl_q;
	logic [HEAD_W-1:0] head_q;
	logic [SEC_W-1:0]  sec_q;

	logic              in_acc;
	logic              out_free;
	logic              out_load;
	logic              op0_err;
	logic              op1_err;
	logic              rem_zero;
	logic [MUL_W-1:0]  lba_full;
	logic [LBA_W-1:0]  geo_rest;
	logic [HEAD_W-1:0] geo_heads;
	logic              geo_fits;

	clgt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	clgt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rem_zero = div_rsp.remainder == '0;

	// coordinate range checks, straight off the input word
	assign op0_err = (cylinder_in >= cfg.cylinder_count) ||
	                 ({1'b0, head_in} >= cfg.head_count) ||
	                 (sector_in == '0) ||
	                 (sector_in > cfg.sectors_per_track);
	assign op1_err = (lba_in >= cfg.total_sectors) ||
	                 (cfg.head_count == '0) ||
	                 (cfg.sectors_per_track == '0);

	// second half of the chs to lba product, wraps to 28 bits
	assign lba_full = MUL_W'(prod_q) * MUL_W'(cfg.sectors_per_track)
	                + MUL_W'(sin_q) - MUL_W'(1);

	// end of the head search: either this divisor fit or we fell to one head
	assign geo_rest  = rem_zero ? div_rsp.quotient : rest_q;
	assign geo_heads = rem_zero ? hd_q : HEAD_W'(1);
	assign geo_fits  = (geo_rest != '0) && (geo_rest <= CYL_MAX);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (op)
						OP_CHS2LBA: state_d = op0_err ? ST_FINISH : ST_MUL;
						OP_LBA2CHS: state_d = op1_err ? ST_FINISH : ST_DIV_SEC;
						OP_GEOM:    state_d = ST_SRCH_SPT;
						default:    state_d = ST_FINISH;
					endcase
				end
			end
			ST_MUL: state_d = ST_FINISH;
			ST_DIV_SEC: begin
				if (div_rsp.done) state_d = ST_DIV_HEAD;
			end
			ST_DIV_HEAD: begin
				if (div_rsp.done) state_d = ST_FINISH;
			end
			ST_SRCH_SPT: begin
				if (div_rsp.done && (rem_zero || spt_q == SPT_W'(2))) state_d = ST_SRCH_HEAD;
			end
			ST_SRCH_HEAD: begin
				if (div_rsp.done && (rem_zero || hd_q == HEAD_W'(2))) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs: divider launches, handshake, output load
	always_comb begin
		div_req  = '0;
		in_stall = state_q != ST_IDLE;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_LBA2CHS && !op1_err) begin
					div_req.start    = 1'b1;
					div_req.dividend = lba_in;
					div_req.divisor  = cfg.sectors_per_track;
				end else if (in_acc && op == OP_GEOM) begin
					div_req.start    = 1'b1;
					div_req.dividend = cfg.total_sectors;
					div_req.divisor  = DSR_W'(SPT_START);
				end
			end
			ST_MUL: ;
			ST_DIV_SEC: begin
				// track number divided by heads
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = div_rsp.quotient;
					div_req.divisor  = DSR_W'(cfg.head_count);
				end
			end
			ST_DIV_HEAD: ;
			ST_SRCH_SPT: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					if (rem_zero) begin
						div_req.dividend = div_rsp.quotient;
						div_req.divisor  = DSR_W'(HEAD_START);
					end else if (spt_q == SPT_W'(2)) begin
						// no divisor found, one sector per track
						div_req.dividend = cfg.total_sectors;
						div_req.divisor  = DSR_W'(HEAD_START);
					end else begin
						div_req.dividend = cfg.total_sectors;
						div_req.divisor  = DSR_W'(spt_q - 1'b1);
					end
				end
			end
			ST_SRCH_HEAD: begin
				if (div_rsp.done && !rem_zero && hd_q != HEAD_W'(2)) begin
					div_req.start    = 1'b1;
					div_req.dividend = rest_q;
					div_req.divisor  = DSR_W'(hd_q - 1'b1);
				end
			end
			ST_FINISH: out_load = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and pending-result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					res_ok_q   <= 1'b0;
					res_lba_q  <= '0;
					res_cyl_q  <= '0;
					res_head_q <= '0;
					res_sec_q  <= '0;
					prod_q     <= PROD_W'(cylinder_in) * PROD_W'(cfg.head_count)
					            + PROD_W'(head_in);
					sin_q      <= sector_in;
					spt_q      <= SPT_START;
					case (op)
						OP_CHS2LBA: begin
							if (op0_err) res_lba_q <= cfg.total_sectors;
						end
						OP_LBA2CHS: begin
							if (op1_err) begin
								res_cyl_q <= cfg.cylinder_count;
								res_sec_q <= SEC_W'(1);
							end
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				res_ok_q  <= 1'b1;
				res_lba_q <= lba_full[LBA_W-1:0];
			end
			ST_DIV_SEC: begin
				if (div_rsp.done) res_sec_q <= div_rsp.remainder + 1'b1;
			end
			ST_DIV_HEAD: begin
				if (div_rsp.done) begin
					res_ok_q   <= 1'b1;
					res_cyl_q  <= div_rsp.quotient[CYL_W-1:0];
					res_head_q <= div_rsp.remainder[HEAD_W-1:0];
				end
			end
			ST_SRCH_SPT: begin
				if (div_rsp.done) begin
					if (rem_zero) begin
						rest_q <= div_rsp.quotient;
						hd_q   <= HEAD_START;
					end else if (spt_q == SPT_W'(2)) begin
						spt_q  <= SPT_W'(1);
						rest_q <= cfg.total_sectors;
						hd_q   <= HEAD_START;
					end else begin
						spt_q <= spt_q - 1'b1;
					end
				end
			end
			ST_SRCH_HEAD: begin
				if (div_rsp.done) begin
					if (rem_zero || hd_q == HEAD_W'(2)) begin
						if (geo_fits) begin
							res_ok_q   <= 1'b1;
							res_cyl_q  <= geo_rest[CYL_W-1:0];
							res_head_q <= geo_heads;
							res_sec_q  <= SEC_W'(spt_q);
						end
					end else begin
						hd_q <= hd_q - 1'b1;
					end
				end
			end
			ST_FINISH: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			ok_q   <= res_ok_q;
			lba_q  <= res_lba_q;
			cyl_q  <= res_cyl_q;
			head_q <= res_head_q;
			sec_q  <= res_sec_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign ok           = ok_q;
	assign lba_out      = lba_q;
	assign cylinder_out = cyl_q;
	assign head_out     = head_q;
	assign sector_out   = sec_q;

	// a taken word keeps the input stalled in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a word was taken");

	// a new result only comes out of the finish step
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result word appeared outside the finish step");

	// the divider is only launched when idle and never by zero
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy && div_req.divisor != '0)
		else $error("divider launched while busy or with a zero divisor");

	// divider completion is only awaited by a dividing step
	a_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV_SEC || state_q == ST_DIV_HEAD ||
		                 state_q == ST_SRCH_SPT || state_q == ST_SRCH_HEAD)
		else $error("divider finished with no step waiting for it");

endmodule
`default_nettype wire

FILE: tb/chs_lba_geometry_translator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_lba_geometry_translator_test
// self-checking bench for the cylinder/head/sector <-> linear address translator
// ----------------------------------------------------------------------------
// Words go in and come out over valid/stall handshakes. A scoreboard keeps a
// mirror of the geometry registers, works out the answer of every accepted
// word and compares each result word field by field, in order. A directed
// pass covers reset values, range edges, wrap and truncation corners, then
// about 1100 random words run over a series of random geometries, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module chs_lba_geometry_translator_test import clgt_pkg::*;;

	// the unused op code has no name in the package
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// default geometry search bounds
	localparam int unsigned SPT_SEARCH_TOP  = 63;
	localparam int unsigned HEAD_SEARCH_TOP = 16;
	localparam int unsigned CYL_LIMIT       = 65535;

	// run shape
	localparam int RANDOM_PHASES = 11;
	localparam int WORDS_PER_PHASE = 100;
	localparam int RANDOM_WORDS = RANDOM_PHASES * WORDS_PER_PHASE;
	localparam int TAIL_CYCLES = 200;
	// worst case is every word a full geometry search plus stalls
	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CYL_W-1:0]  cyl;
		logic [HIN_W-1:0]  head;
		logic [SEC_W-1:0]  sec;
		logic [LBA_W-1:0]  lba;
	} request_t;

	typedef struct packed {
		logic              ok;
		logic [LBA_W-1:0]  lba;
		logic [CYL_W-1:0]  cyl;
		logic [HEAD_W-1:0] head;
		logic [SEC_W-1:0]  sec;
	} answer_t;

	// mirror of the geometry registers plus the queue of pending answers
	class geometry_scoreboard;
		logic [LBA_W-1:0]  total;
		logic [CYL_W-1:0]  cyl_count;
		logic [HEAD_W-1:0] head_count;
		logic [SEC_W-1:0]  spt_count;
		answer_t           answer_q[$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       range_errors;
		int unsigned       op_seen[4];

		function new();
			total = '0;
			cyl_count = '0;
			head_count = '0;
			spt_count = '0;
			mismatches = 0;
			checked = 0;
			range_errors = 0;
			foreach (op_seen[i]) op_seen[i] = 0;
		endfunction

		function void set_register(logic [IDX_W-1:0] idx, logic [LBA_W-1:0] value);
			case (idx)
				REG_TOTAL_SECTORS: total = value;
				REG_CYL_COUNT:     cyl_count = value[CYL_W-1:0];
				REG_HEAD_COUNT:    head_count = value[HEAD_W-1:0];
				REG_SPT:           spt_count = value[SEC_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return answer_q.size();
		endfunction

		// expected answer of one word under the current geometry
		function answer_t translate(request_t w);
			answer_t a;
			int unsigned rest, quo, spt, hd;
			a = '0;
			case (w.op)
				OP_CHS2LBA: begin
					if (w.cyl >= cyl_count || w.head >= head_count || w.sec == 0 ||
							w.sec > spt_count) begin
						a.lba = total;
					end else begin
						rest = (32'(w.cyl) * 32'(head_count) + 32'(w.head)) * 32'(spt_count)
							+ 32'(w.sec) - 1;
						a.ok = 1'b1;
						a.lba = rest[LBA_W-1:0];
					end
				end
				OP_LBA2CHS: begin
					if (w.lba >= total || head_count == 0 || spt_count == 0) begin
						a.cyl = cyl_count;
						a.sec = 8'd1;
					end else begin
						quo = 32'(w.lba) / 32'(spt_count);
						rest = 32'(w.lba) % 32'(spt_count) + 1;
						a.sec = rest[SEC_W-1:0];
						rest = quo % 32'(head_count);
						a.head = rest[HEAD_W-1:0];
						rest = quo / 32'(head_count);
						a.cyl = rest[CYL_W-1:0];
						a.ok = 1'b1;
					end
				end
				OP_GEOM: begin
					rest = 32'(total);
					spt = SPT_SEARCH_TOP;
					while (spt > 1 && rest % spt != 0) spt--;
					rest = rest / spt;
					hd = HEAD_SEARCH_TOP;
					while (hd > 1 && rest % hd != 0) hd--;
					rest = rest / hd;
					if (rest >= 1 && rest <= CYL_LIMIT) begin
						a.ok = 1'b1;
						a.cyl = rest[CYL_W-1:0];
						a.head = hd[HEAD_W-1:0];
						a.sec = spt[SEC_W-1:0];
					end
				end
				default: ;
			endcase
			return a;
		endfunction

		function void note_request(request_t w);
			op_seen[w.op]++;
			answer_q.push_back(translate(w));
		endfunction

		task report_mismatch(string msg);
			if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(answer_t got);
			answer_t want;
			if (answer_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending (ok %0d lba %0h)",
					got.ok, got.lba));
			end else begin
				want = answer_q.pop_front();
				checked++;
				if (!want.ok) range_errors++;
				if (got.ok !== want.ok)
					report_mismatch($sformatf("ok %0d, want %0d", got.ok, want.ok));
				if (got.lba !== want.lba)
					report_mismatch($sformatf("lba_out %0h, want %0h", got.lba, want.lba));
				if (got.cyl !== want.cyl)
					report_mismatch($sformatf("cylinder_out %0d, want %0d", got.cyl, want.cyl));
				if (got.head !== want.head)
					report_mismatch($sformatf("head_out %0d, want %0d", got.head, want.head));
				if (got.sec !== want.sec)
					report_mismatch($sformatf("sector_out %0d, want %0d", got.sec, want.sec));
			end
		endtask
	endclass

	// clock, reset and block inputs, all known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [LBA_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic [OP_W-1:0]   op = '0;
	logic [CYL_W-1:0]  cylinder_in = '0;
	logic [HIN_W-1:0]  head_in = '0;
	logic [SEC_W-1:0]  sector_in = '0;
	logic [LBA_W-1:0]  lba_in = '0;
	logic              out_stall = 1'b0;

	// block outputs
	logic              in_stall;
	logic              out_valid;
	logic              ok;
	logic [LBA_W-1:0]  lba_out;
	logic [CYL_W-1:0]  cylinder_out;
	logic [HEAD_W-1:0] head_out;
	logic [SEC_W-1:0]  sector_out;

	geometry_scoreboard sb = new();

	// idle percentages of the two sides, changed as the run goes on
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cycles = 0;
	int unsigned settings_used = 0;

	chs_lba_geometry_translator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.cylinder_in  (cylinder_in),
		.head_in      (head_in),
		.sector_in    (sector_in),
		.lba_in       (lba_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.lba_out      (lba_out),
		.cylinder_out (cylinder_out),
		.head_out     (head_out),
		.sector_out   (sector_out)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				sb.pending());
			$display("chs_lba_geometry_translator test failed");
			$finish;
		end
	end

	// receiver side: random stall at the configured rate
	always @(posedge clk)
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

	// both handshakes are sampled with pre-edge values
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_request(request_t'{op, cylinder_in, head_in, sector_in, lba_in});
		if (arst_n && out_valid && !out_stall)
			sb.check_result(answer_t'{ok, lba_out, cylinder_out, head_out, sector_out});
	end

	function automatic request_t make_word(logic [OP_W-1:0] o, int unsigned c, int unsigned h,
			int unsigned s, int unsigned b);
		request_t w;
		w.op = o;
		w.cyl = c[CYL_W-1:0];
		w.head = h[HIN_W-1:0];
		w.sec = s[SEC_W-1:0];
		w.lba = b[LBA_W-1:0];
		return w;
	endfunction

	// offer one word, with random idle cycles ahead of it; valid stays up after
	// the accept so the next word can follow back to back
	task automatic send_word(input request_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		cylinder_in <= w.cyl;
		head_in <= w.head;
		sector_in <= w.sec;
		lba_in <= w.lba;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off the sender until every pending result has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [LBA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	// new geometry, written only once the block is idle; narrow registers get
	// junk above their width to check the masking
	task automatic program_geometry(input logic [LBA_W-1:0] total, input int unsigned cyl,
			input int unsigned heads, input int unsigned spt);
		logic [LBA_W-1:0] junk;
		drain();
		junk = LBA_W'($urandom);
		write_register(REG_TOTAL_SECTORS, total);
		write_register(REG_CYL_COUNT, LBA_W'(cyl) | (junk << CYL_W));
		write_register(REG_HEAD_COUNT, LBA_W'(heads) | (junk << HEAD_W));
		write_register(REG_SPT, LBA_W'(spt) | (junk << SEC_W));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_directed();
		// reset geometry: everything is an error
		send_word(make_word(OP_CHS2LBA, 0, 0, 1, 0));
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 0));
		send_word(make_word(OP_GEOM, 0, 0, 0, 0));
		send_word(make_word(OP_UNUSED, 16'hFFFF, 4'hF, 8'hFF, 28'hFFFFFFF));

		// ordinary 1024/16/63 disk
		program_geometry(28'd1032192, 1024, 16, 63);
		send_word(make_word(OP_CHS2LBA, 0, 0, 1, 0));
		send_word(make_word(OP_CHS2LBA, 1023, 15, 63, 0));
		send_word(make_word(OP_CHS2LBA, 5, 3, 0, 0));          // sector zero
		send_word(make_word(OP_CHS2LBA, 5, 3, 64, 0));         // sector past track end
		send_word(make_word(OP_CHS2LBA, 1024, 0, 1, 0));       // cylinder out of range
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 0));
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 1032191));
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 1032192));    // first address past end
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 28'hFFFFFFF));
		send_word(make_word(OP_GEOM, 0, 0, 0, 0));

		// oversize head count: the address wraps at 28 bits
		program_geometry(28'hFFFFFFF, 65535, 31, 255);
		send_word(make_word(OP_CHS2LBA, 65534, 15, 255, 0));
		send_word(make_word(OP_CHS2LBA, 65535, 0, 1, 0));
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 28'hFFFFFFE));
		send_word(make_word(OP_GEOM, 0, 0, 0, 0));

		// one head, one sector: the cylinder quotient is cut to 16 bits
		program_geometry(28'hFFFFFFF, 0, 1, 1);
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 28'hFFFFFFE));
		send_word(make_word(OP_CHS2LBA, 0, 0, 1, 0));

		// zero heads, then zero sectors per track: lba to chs must refuse
		program_geometry(28'd1000, 10, 0, 5);
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 3));
		send_word(make_word(OP_CHS2LBA, 0, 0, 1, 0));
		program_geometry(28'd1000, 10, 4, 0);
		send_word(make_word(OP_LBA2CHS, 0, 0, 0, 3));
	endtask

	// mostly legal coordinates and addresses for the current geometry, some
	// noise; geometry searches kept rare since they are slow
	function automatic request_t random_word();
		request_t w;
		int unsigned pick, hmax;
		w.cyl = CYL_W'($urandom);
		w.head = HIN_W'($urandom);
		w.sec = SEC_W'($urandom);
		w.lba = LBA_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 45) w.op = OP_CHS2LBA;
		else if (pick < 85) w.op = OP_LBA2CHS;
		else if (pick < 93) w.op = OP_GEOM;
		else w.op = OP_UNUSED;
		if ($urandom_range(99) < 85) begin
			if (w.op == OP_CHS2LBA && sb.cyl_count != 0 && sb.head_count != 0 &&
					sb.spt_count != 0) begin
				hmax = (sb.head_count > 16) ? 16 : 32'(sb.head_count);
				w.cyl = CYL_W'($urandom_range(32'(sb.cyl_count) - 1));
				w.head = HIN_W'($urandom_range(hmax - 1));
				w.sec = SEC_W'($urandom_range(32'(sb.spt_count), 1));
			end
			if (w.op == OP_LBA2CHS && sb.total != 0)
				w.lba = LBA_W'($urandom_range(32'(sb.total) - 1));
		end
		return w;
	endfunction

	task automatic run_random();
		int unsigned kind, cyl, heads, spt, slack, total, sent;
		sent = 0;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			kind = $urandom_range(3);
			if (p == 0) begin
				// all registers at their widest
				program_geometry(28'hFFFFFFF, 65535, 31, 255);
			end else if (p == 1) begin
				// smallest real disk, slowest geometry search
				program_geometry(28'd1, 1, 1, 1);
			end else if (kind <= 1) begin
				// consistent geometry within the search bounds
				cyl = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(2000, 1);
				heads = $urandom_range(16, 1);
				spt = $urandom_range(63, 1);
				program_geometry(LBA_W'(cyl * heads * spt), cyl, heads, spt);
			end else if (kind == 2) begin
				// wide tracks, capacity a little short of the geometry
				cyl = $urandom_range(65535, 1);
				heads = $urandom_range(16, 1);
				spt = $urandom_range(255, 1);
				slack = $urandom_range(1000);
				total = cyl * heads * spt;
				total = (total > slack) ? total - slack : total;
				program_geometry(LBA_W'(total), cyl, heads, spt);
			end else begin
				// anything the registers hold
				total = ($urandom_range(1) == 0) ? $urandom_range(5000) : $urandom;
				program_geometry(LBA_W'(total), $urandom_range(65535), $urandom_range(31),
					$urandom_range(255));
			end
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				// receiver idles more first, then the sender, then full rate
				if (sent < RANDOM_WORDS / 3) begin
					send_idle_pct = 19;
					recv_idle_pct = 46;
				end else if (sent < 2 * RANDOM_WORDS / 3) begin
					send_idle_pct = 46;
					recv_idle_pct = 19;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				if ($urandom_range(99) < 2) drain();
				send_word(random_word());
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 19;
		recv_idle_pct = 46;
		run_directed();
		run_random();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d results never came", sb.pending()));
		$display("covered %0d words (chs->lba %0d, lba->chs %0d, geometry %0d, unused op %0d)",
			sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3], sb.op_seen[0],
			sb.op_seen[1], sb.op_seen[2], sb.op_seen[3]);
		$display("over %0d geometry settings: %0d results checked, %0d errors, %0d mismatches",
			settings_used, sb.checked, sb.range_errors, sb.mismatches);
		if (sb.mismatches == 0)
			$display("chs_lba_geometry_translator test passed");
		else
			$display("chs_lba_geometry_translator test failed");
		$finish;
	end

endmodule
